FILE: hdl/owb_pkg.sv
// shared types and constants for the one-wire bus master core
package owb_pkg;

  // command codes carried in the action field
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_RESET = 3'd1,
    ACT_WBYTE = 3'd2,
    ACT_RBYTE = 3'd3,
    ACT_WBIT  = 3'd4,
    ACT_RBIT  = 3'd5
  } act_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_WRITE_ONE_LOW = 3'd3,
    CFG_WRITE_ZERO_LOW = 3'd4,
    CFG_WRITE_SLOT    = 3'd5,
    CFG_READ_LOW      = 3'd6,
    CFG_READ_SAMPLE   = 3'd7
  } cfg_idx_e;

  // bus phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_TAIL = 4'b1000
  } phase_e;

  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [9:0] READ_TAIL_TICKS = 10'd55;

  // register reset values
  localparam logic [9:0] RST_RESET_LOW      = 10'd480;
  localparam logic [9:0] RST_PRESENCE_WAIT  = 10'd70;
  localparam logic [9:0] RST_RESET_TAIL     = 10'd410;
  localparam logic [6:0] RST_WRITE_ONE_LOW  = 7'd6;
  localparam logic [6:0] RST_WRITE_ZERO_LOW = 7'd60;
  localparam logic [7:0] RST_WRITE_SLOT     = 8'd70;
  localparam logic [5:0] RST_READ_LOW       = 6'd3;
  localparam logic [5:0] RST_READ_SAMPLE    = 6'd10;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_wait_time;
    logic [9:0] reset_tail_time;
    logic [6:0] write_one_low_time;
    logic [6:0] write_zero_low_time;
    logic [7:0] write_slot_time;
    logic [5:0] read_low_time;
    logic [5:0] read_sample_delay;
  } cfg_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic [9:0] time_count;
    logic [2:0] operation;
    logic [7:0] shift_data;
    logic [3:0] slots_left;
    logic       presence_flag;
  } state_t;

endpackage

FILE: hdl/owb_cfg.sv
// timing configuration registers of the one-wire bus master
module owb_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_addr_i,
  input  logic [owb_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output owb_pkg::cfg_t                    cfg_o
);

  owb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time      <= owb_pkg::RST_RESET_LOW;
      cfg_q.presence_wait_time  <= owb_pkg::RST_PRESENCE_WAIT;
      cfg_q.reset_tail_time     <= owb_pkg::RST_RESET_TAIL;
      cfg_q.write_one_low_time  <= owb_pkg::RST_WRITE_ONE_LOW;
      cfg_q.write_zero_low_time <= owb_pkg::RST_WRITE_ZERO_LOW;
      cfg_q.write_slot_time     <= owb_pkg::RST_WRITE_SLOT;
      cfg_q.read_low_time       <= owb_pkg::RST_READ_LOW;
      cfg_q.read_sample_delay   <= owb_pkg::RST_READ_SAMPLE;
    end else if (cfg_we_i) begin
      unique case (owb_pkg::cfg_idx_e'(cfg_addr_i))
        owb_pkg::CFG_RESET_LOW:      cfg_q.reset_low_time      <= cfg_wdata_i[9:0];
        owb_pkg::CFG_PRESENCE_WAIT:  cfg_q.presence_wait_time  <= cfg_wdata_i[9:0];
        owb_pkg::CFG_RESET_TAIL:     cfg_q.reset_tail_time     <= cfg_wdata_i[9:0];
        owb_pkg::CFG_WRITE_ONE_LOW:  cfg_q.write_one_low_time  <= cfg_wdata_i[6:0];
        owb_pkg::CFG_WRITE_ZERO_LOW: cfg_q.write_zero_low_time <= cfg_wdata_i[6:0];
        owb_pkg::CFG_WRITE_SLOT:     cfg_q.write_slot_time     <= cfg_wdata_i[7:0];
        owb_pkg::CFG_READ_LOW:       cfg_q.read_low_time       <= cfg_wdata_i[5:0];
        owb_pkg::CFG_READ_SAMPLE:    cfg_q.read_sample_delay   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/owb_step.sv
// next-state and result logic for one microsecond tick
module owb_step (
  input  owb_pkg::state_t    state_i,
  input  owb_pkg::cfg_t      cfg_i,
  input  owb_pkg::in_item_t  item_i,
  output owb_pkg::state_t    state_o,
  output owb_pkg::out_item_t res_o
);

  // zero durations count as one tick
  function automatic logic [9:0] at_least_one(input logic [9:0] v);
    at_least_one = (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic logic is_wr(input logic [2:0] op);
    is_wr = (op == owb_pkg::ACT_WBYTE) || (op == owb_pkg::ACT_WBIT);
  endfunction

  function automatic logic is_rd(input logic [2:0] op);
    is_rd = (op == owb_pkg::ACT_RBYTE) || (op == owb_pkg::ACT_RBIT);
  endfunction

  function automatic logic [6:0] wr_low(input logic sh0, input owb_pkg::cfg_t c);
    logic [6:0] v;
    v = sh0 ? c.write_one_low_time : c.write_zero_low_time;
    wr_low = (v == 7'd0) ? 7'd1 : v;
  endfunction

  // length of the low phase that opens a slot
  function automatic logic [9:0] start_len(input logic [2:0] op, input logic sh0,
                                           input owb_pkg::cfg_t c);
    if (op == owb_pkg::ACT_RESET) begin
      start_len = at_least_one(c.reset_low_time);
    end else if (is_wr(op)) begin
      start_len = {3'd0, wr_low(sh0, c)};
    end else begin
      start_len = at_least_one({4'd0, c.read_low_time});
    end
  endfunction

  owb_pkg::state_t st;
  logic [2:0]      act;
  logic            cmd;
  logic            do_end;
  logic [6:0]      low;
  logic [7:0]      rel;
  logic [9:0]      tail_len;

  always_comb begin
    st       = state_i;
    res_o    = '0;
    act      = item_i.action;
    cmd      = (act >= owb_pkg::ACT_RESET) && (act <= owb_pkg::ACT_RBIT);
    do_end   = 1'b0;
    low      = '0;
    rel      = '0;
    tail_len = '0;

    if (st.phase != owb_pkg::PH_LOW && st.phase != owb_pkg::PH_WAIT &&
        st.phase != owb_pkg::PH_TAIL) begin
      st.phase = owb_pkg::PH_IDLE;
    end

    if (st.phase == owb_pkg::PH_IDLE) begin
      if (cmd) begin
        st.operation  = act;
        st.slots_left = (act == owb_pkg::ACT_WBYTE || act == owb_pkg::ACT_RBYTE) ?
                        owb_pkg::BITS_PER_BYTE : 4'd1;
        if (act == owb_pkg::ACT_WBYTE) begin
          st.shift_data = item_i.data_byte;
        end else if (act == owb_pkg::ACT_WBIT) begin
          st.shift_data = {7'd0, item_i.data_byte[0]};
        end else begin
          st.shift_data = 8'd0;
        end
        st.phase      = owb_pkg::PH_LOW;
        st.time_count = start_len(act, st.shift_data[0], cfg_i);
      end
    end else if (cmd) begin
      res_o.rejected = 1'b1;
    end

    if (st.phase != owb_pkg::PH_IDLE) begin
      res_o.busy_res  = 1'b1;
      res_o.drive_low = (st.phase == owb_pkg::PH_LOW);

      // sample on the last tick of the wait phase
      if (st.phase == owb_pkg::PH_WAIT && st.time_count == 10'd1) begin
        if (st.operation == owb_pkg::ACT_RESET) begin
          st.presence_flag = ~item_i.line_level;
        end else if (st.operation == owb_pkg::ACT_RBYTE) begin
          st.shift_data = {item_i.line_level, st.shift_data[7:1]};
        end else if (st.operation == owb_pkg::ACT_RBIT) begin
          st.shift_data = {7'd0, item_i.line_level};
        end
      end

      if (st.time_count != 10'd0) begin
        st.time_count = st.time_count - 10'd1;
      end

      if (st.time_count == 10'd0) begin
        unique case (st.phase)
          owb_pkg::PH_LOW: begin
            if (is_wr(st.operation)) begin
              low = wr_low(st.shift_data[0], cfg_i);
              rel = (cfg_i.write_slot_time > {1'b0, low}) ?
                    cfg_i.write_slot_time - {1'b0, low} : 8'd0;
              if (rel == 8'd0) begin
                do_end = 1'b1;
              end else begin
                st.phase      = owb_pkg::PH_TAIL;
                st.time_count = {2'd0, rel};
              end
            end else begin
              st.phase      = owb_pkg::PH_WAIT;
              st.time_count = at_least_one((st.operation == owb_pkg::ACT_RESET) ?
                                           cfg_i.presence_wait_time :
                                           {4'd0, cfg_i.read_sample_delay});
            end
          end
          owb_pkg::PH_WAIT: begin
            tail_len = (st.operation == owb_pkg::ACT_RESET) ?
                       cfg_i.reset_tail_time : owb_pkg::READ_TAIL_TICKS;
            if (tail_len == 10'd0) begin
              do_end = 1'b1;
            end else begin
              st.phase      = owb_pkg::PH_TAIL;
              st.time_count = tail_len;
            end
          end
          owb_pkg::PH_TAIL: begin
            do_end = 1'b1;
          end
          default: ;
        endcase
      end

      if (do_end) begin
        if (is_wr(st.operation)) begin
          st.shift_data = {1'b0, st.shift_data[7:1]};
        end
        if (st.slots_left > 4'd1) begin
          st.slots_left = st.slots_left - 4'd1;
          st.phase      = owb_pkg::PH_LOW;
          st.time_count = start_len(st.operation, st.shift_data[0], cfg_i);
        end else begin
          st.slots_left = 4'd0;
          st.phase      = owb_pkg::PH_IDLE;
          st.time_count = 10'd0;
          res_o.done_res = 1'b1;
          if (is_rd(st.operation)) begin
            res_o.read_data = st.shift_data;
          end
        end
      end
    end

    res_o.presence = st.presence_flag;
    state_o        = st;
  end

endmodule

FILE: hdl/one_wire_bus_master_core.sv
// top level of the one-wire bus master core
//
// usage:
//   every request on the input channel is one microsecond tick: an action
//   (tick only, bus reset, write/read byte, write/read bit), a data byte and
//   the bus level sampled during that microsecond. each accepted request gives
//   exactly one result: line drive, busy, done pulse, presence and read data,
//   plus a rejected flag when a command came in while an operation ran.
//   the result is registered: it shows on the output channel in the cycle after
//   the request is taken, and a new request is taken every cycle as long as
//   the output register is empty or being drained (one tick per cycle).
//   the bus sequencer updates only on accepted ticks, so stalls on either side
//   stretch nothing but wall-clock time; the bus timing is counted in ticks.
//   if the receiver stalls, the result holds and in_ready_o drops until it
//   is taken.
//   timing registers are to be written through the cfg port while idle; the
//   block does not enforce this, and a write is used from the next phase change on.
//   reset puts the sequencer idle, clears presence and loads default timing
//   (480/70/410 us reset, 6/60/70 us write, 3/10 us read).
module one_wire_bus_master_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // timing configuration writes
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_addr_i,
  input  logic [owb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // tick requests
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  owb_pkg::in_item_t              in_data_i,
  // per-tick results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output owb_pkg::out_item_t             out_data_o
);

  owb_pkg::cfg_t      cfg;
  owb_pkg::state_t    state_q, state_d;
  owb_pkg::out_item_t res_d, out_data_q;
  logic               out_valid_q;
  logic               accept;

  owb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // whole tick evaluated between the state register and the result register
  owb_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .item_i  (in_data_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // take a request whenever the result slot is free or draining this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // sequencer state advances one tick per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= owb_pkg::PH_IDLE;
      state_q.time_count    <= '0;
      state_q.operation     <= '0;
      state_q.shift_data    <= '0;
      state_q.slots_left    <= '0;
      state_q.presence_flag <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // idle sequencer holds no leftover slot count or timer
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == owb_pkg::PH_IDLE) |->
      (state_q.slots_left == 4'd0 && state_q.time_count == 10'd0))
    else $error("idle phase with pending slots or timer");

  // an active phase always has ticks left
  a_active_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != owb_pkg::PH_IDLE) |-> (state_q.time_count != 10'd0))
    else $error("active phase with zero timer");

  // read data only shows on a completion tick
  a_rdata_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.read_data != 8'd0) |-> out_data_o.done_res)
    else $error("read data outside a done tick");

  // a command is only rejected while the bus is busy
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rejected) |-> out_data_o.busy_res)
    else $error("rejected flag on an idle tick");

endmodule

FILE: bench/owb_checker.sv
// result checker for the one-wire bus master core: tick-by-tick bus sequencer mirror
module owb_checker
  import owb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output logic                  bus_idle_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        timing;
  phase_e      bus_phase;
  logic [9:0]  ticks_left;
  act_e        cur_op;
  logic [7:0]  shift_reg;
  logic [3:0]  slots_left;
  logic        presence_q;
  out_item_t   expected_ticks[$];
  int unsigned mismatch_cnt;
  int unsigned result_idx;

  function automatic logic [9:0] min_one(input logic [9:0] v);
    return (v == '0) ? 10'd1 : v;
  endfunction

  function automatic logic is_write_op();
    return cur_op == ACT_WBYTE || cur_op == ACT_WBIT;
  endfunction

  function automatic logic is_read_op();
    return cur_op == ACT_RBYTE || cur_op == ACT_RBIT;
  endfunction

  // low part of a write slot depends on the bit being sent
  function automatic logic [9:0] write_low_ticks();
    return min_one({3'b0, shift_reg[0] ? timing.write_one_low_time
                                       : timing.write_zero_low_time});
  endfunction

  function automatic void open_slot();
    bus_phase = PH_LOW;
    if (cur_op == ACT_RESET) begin
      ticks_left = min_one(timing.reset_low_time);
    end else if (is_write_op()) begin
      ticks_left = write_low_ticks();
    end else begin
      ticks_left = min_one({4'b0, timing.read_low_time});
    end
  endfunction

  // returns 1 when the whole operation has finished
  function automatic bit close_slot();
    if (is_write_op()) shift_reg = shift_reg >> 1;
    if (slots_left > 4'd1) begin
      slots_left--;
      open_slot();
      return 1'b0;
    end
    slots_left = '0;
    bus_phase  = PH_IDLE;
    ticks_left = '0;
    return 1'b1;
  endfunction

  function automatic bit enter_tail(input logic [9:0] len);
    if (len == '0) return close_slot();
    bus_phase  = PH_TAIL;
    ticks_left = len;
    return 1'b0;
  endfunction

  function automatic bit next_phase();
    logic [9:0] low_len;
    logic [9:0] slot_len;
    if (bus_phase == PH_LOW) begin
      if (is_write_op()) begin
        low_len  = write_low_ticks();
        slot_len = {2'b0, timing.write_slot_time};
        return enter_tail(slot_len > low_len ? slot_len - low_len : 10'd0);
      end
      bus_phase  = PH_WAIT;
      ticks_left = min_one(cur_op == ACT_RESET ? timing.presence_wait_time
                                               : {4'b0, timing.read_sample_delay});
      return 1'b0;
    end
    if (bus_phase == PH_WAIT) begin
      return enter_tail(cur_op == ACT_RESET ? timing.reset_tail_time : READ_TAIL_TICKS);
    end
    return close_slot();
  endfunction

  function automatic void sample_line(input logic lvl);
    case (cur_op)
      ACT_RESET: presence_q = ~lvl;
      ACT_RBYTE: shift_reg  = {lvl, shift_reg[7:1]};
      ACT_RBIT:  shift_reg  = {7'b0, lvl};
      default: ;
    endcase
  endfunction

  function automatic out_item_t bus_tick_predict(input in_item_t req);
    out_item_t res;
    logic      is_cmd;
    res    = '0;
    is_cmd = req.action >= ACT_RESET && req.action <= ACT_RBIT;
    if (bus_phase == PH_IDLE) begin
      if (is_cmd) begin
        cur_op     = act_e'(req.action);
        slots_left = (cur_op == ACT_WBYTE || cur_op == ACT_RBYTE) ? BITS_PER_BYTE : 4'd1;
        case (cur_op)
          ACT_WBYTE: shift_reg = req.data_byte;
          ACT_WBIT:  shift_reg = {7'b0, req.data_byte[0]};
          default:   shift_reg = '0;
        endcase
        open_slot();
      end
    end else if (is_cmd) begin
      res.rejected = 1'b1;
    end
    if (bus_phase != PH_IDLE) begin
      res.busy_res  = 1'b1;
      res.drive_low = bus_phase == PH_LOW;
      if (bus_phase == PH_WAIT && ticks_left == 10'd1) sample_line(req.line_level);
      if (ticks_left != '0) ticks_left--;
      if (ticks_left == '0 && next_phase()) begin
        res.done_res = 1'b1;
        if (is_read_op()) res.read_data = shift_reg;
      end
    end
    res.presence = presence_q;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("result %0d: %s expected %0h got %0h", result_idx, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      timing = '{RST_RESET_LOW, RST_PRESENCE_WAIT, RST_RESET_TAIL, RST_WRITE_ONE_LOW,
                 RST_WRITE_ZERO_LOW, RST_WRITE_SLOT, RST_READ_LOW, RST_READ_SAMPLE};
      bus_phase  = PH_IDLE;
      ticks_left = '0;
      cur_op     = ACT_TICK;
      shift_reg  = '0;
      slots_left = '0;
      presence_q = 1'b0;
      expected_ticks.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_RESET_LOW:      timing.reset_low_time      = cfg_wdata_i[9:0];
          CFG_PRESENCE_WAIT:  timing.presence_wait_time  = cfg_wdata_i[9:0];
          CFG_RESET_TAIL:     timing.reset_tail_time     = cfg_wdata_i[9:0];
          CFG_WRITE_ONE_LOW:  timing.write_one_low_time  = cfg_wdata_i[6:0];
          CFG_WRITE_ZERO_LOW: timing.write_zero_low_time = cfg_wdata_i[6:0];
          CFG_WRITE_SLOT:     timing.write_slot_time     = cfg_wdata_i[7:0];
          CFG_READ_LOW:       timing.read_low_time       = cfg_wdata_i[5:0];
          CFG_READ_SAMPLE:    timing.read_sample_delay   = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      // results leave before this edge's tick is queued
      if (out_valid_i && out_ready_i) begin
        if (expected_ticks.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("result %0d: no tick waiting for it", result_idx);
        end else begin
          want = expected_ticks.pop_front();
          check_field("drive_low", {7'b0, want.drive_low}, {7'b0, out_data_i.drive_low});
          check_field("busy_res",  {7'b0, want.busy_res},  {7'b0, out_data_i.busy_res});
          check_field("done_res",  {7'b0, want.done_res},  {7'b0, out_data_i.done_res});
          check_field("presence",  {7'b0, want.presence},  {7'b0, out_data_i.presence});
          check_field("read_data", want.read_data, out_data_i.read_data);
          check_field("rejected",  {7'b0, want.rejected},  {7'b0, out_data_i.rejected});
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i) expected_ticks.push_back(bus_tick_predict(in_data_i));
    end
    fail_count_o <= mismatch_cnt;
    pending_o    <= expected_ticks.size();
    bus_idle_o   <= bus_phase == PH_IDLE;
  end

endmodule

FILE: bench/tb_top.sv
// testbench top for the one-wire bus master core: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import owb_pkg::*;

  // action codes the block treats as a plain tick
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  // length of the forced receiver hold-off, in cycles
  localparam int unsigned HOLD_CYCLES = 80;

  // receiver stall patterns
  typedef enum int unsigned {RX_STREAM, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [2:0]            cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  logic        bus_idle;

  // sender burst bookkeeping and the hold-off request count
  int unsigned burst_left = 0;
  int unsigned hold_req   = 0;
  logic [9:0]  timing_set [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  one_wire_bus_master_core DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  owb_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .in_data_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .bus_idle_o   (bus_idle)
  );

  // offer one tick and hold it until taken; between bursts the sender may go quiet, unless steady
  task automatic send_tick(input in_item_t req, input bit steady);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [2:0] any_command();
    return 3'($urandom_range(int'(ACT_RESET), int'(ACT_RBIT)));
  endfunction

  // tick the bus until the running operation is over, line held at one level
  // note: the idle flag lags by one accepted tick, so one plain tick goes first
  task automatic settle_bus(input logic lvl);
    in_item_t req;
    req = '{action: ACT_TICK, data_byte: 8'($urandom), line_level: lvl};
    send_tick(req, 1'b0);
    while (!bus_idle) send_tick(req, 1'b0);
  endtask

  // sender pauses until every queued request has produced its result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // timing registers only change with the bus idle and nothing in flight
  task automatic load_timing();
    settle_bus(1'($urandom_range(0, 1)));
    drain_results();
    foreach (timing_set[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= cfg_idx_e'(i);
      cfg_wdata_i <= timing_set[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // one command, a second request right behind it (while busy unless the op already ended), then run to the end
  task automatic run_cmd(input logic [2:0] act, input logic [7:0] data, input logic lvl,
                         input logic [2:0] follow);
    in_item_t req;
    req = '{action: act, data_byte: data, line_level: lvl};
    send_tick(req, 1'b0);
    req.action    = follow;
    req.data_byte = ~data;
    send_tick(req, 1'b0);
    settle_bus(lvl);
  endtask

  // mostly well-formed traffic: usually a command when the bus looks idle, ticks in
  // between, a few commands thrown at a busy bus and some spare action codes
  task automatic run_random(input int unsigned count, input bit steady);
    in_item_t    req;
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      req.data_byte  = 8'($urandom);
      req.line_level = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (bus_idle && roll < 70) begin
        req.action = any_command();
      end else if (roll < 3) begin
        req.action = any_command();
      end else if (roll < 8) begin
        req.action = 3'($urandom_range(int'(ACT_SPARE_A), int'(ACT_SPARE_B)));
      end else begin
        req.action = ACT_TICK;
      end
      send_tick(req, steady);
    end
  endtask

  // mostly short timings so that many operations fit, now and then a full-width value
  task automatic pick_timing();
    foreach (timing_set[i]) begin
      if ($urandom_range(0, 9) == 0) begin
        timing_set[i] = 10'($urandom);
      end else begin
        timing_set[i] = 10'($urandom_range(0, 7));
      end
    end
  endtask

  // receiver: random stall patterns, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int unsigned stretch;
    int unsigned hold_left;
    int unsigned holds_seen;
    rx_mode_e    mode;
    stretch    = 0;
    hold_left  = 0;
    holds_seen = 0;
    mode       = RX_STREAM;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req != holds_seen) begin
        holds_seen  = hold_req;
        hold_left   = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(8, 64);
        end
        stretch--;
        case (mode)
          RX_STREAM:   out_ready_i <= 1'b1;
          RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready_i <= (stretch % 3) != 0;
          default:     out_ready_i <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset-value timing, no register written yet
    run_random(150, 1'b0);

    // shortest legal timing: directed pass over every command and corner
    timing_set = '{10'd1, 10'd1, 10'd0, 10'd1, 10'd1, 10'd2, 10'd1, 10'd0};
    load_timing();
    run_cmd(ACT_RESET, 8'h00, 1'b0, any_command());  // device answers
    run_cmd(ACT_RESET, 8'hFF, 1'b1, any_command());  // nobody on the bus, zero tail
    run_cmd(ACT_WBYTE, 8'h00, 1'b1, any_command());
    run_cmd(ACT_WBYTE, 8'hFF, 1'b1, ACT_SPARE_A);    // spare code while busy
    run_cmd(ACT_WBYTE, 8'hA5, 1'b0, any_command());
    run_cmd(ACT_WBIT,  8'hFE, 1'b1, any_command());  // only bit 0 counts, done tick hit
    run_cmd(ACT_WBIT,  8'h01, 1'b0, ACT_SPARE_B);
    run_cmd(ACT_RBIT,  8'h00, 1'b0, any_command());
    run_cmd(ACT_RBIT,  8'h00, 1'b1, ACT_TICK);
    run_cmd(ACT_RBYTE, 8'h00, 1'b1, any_command());
    run_cmd(ACT_RBYTE, 8'h55, 1'b0, any_command());
    run_cmd(ACT_SPARE_A, 8'hFF, 1'b0, ACT_SPARE_B);  // spare codes while idle

    // every register zero: low times act as one tick, write slot shorter than low
    timing_set = '{default: 10'd0};
    load_timing();
    run_cmd(ACT_WBIT,  8'h00, 1'b1, ACT_WBIT);       // one-tick op, next command starts
    run_cmd(ACT_WBYTE, 8'h5A, 1'b0, any_command());
    run_cmd(ACT_RESET, 8'h00, 1'b0, any_command());
    run_cmd(ACT_RBIT,  8'h00, 1'b1, any_command());

    // upper bits set on the write bus: each narrow register keeps only its own width
    timing_set = '{10'd2, 10'd2, 10'd2, 10'h302, 10'h382, 10'h303, 10'h3C2, 10'h3C1};
    load_timing();
    run_cmd(ACT_RESET, 8'h00, 1'b0, any_command());
    run_cmd(ACT_WBYTE, 8'h96, 1'b1, any_command());
    run_cmd(ACT_RBIT,  8'h00, 1'b1, any_command());
    run_cmd(ACT_WBIT,  8'h01, 1'b0, any_command());

    // random timing sets with random traffic
    for (int unsigned p = 0; p < 6; p++) begin
      pick_timing();
      load_timing();
      if (p == 0) begin
        // receiver holds off while the sender keeps offering, so the block backs up
        hold_req <= hold_req + 1;
        run_random(190, 1'b1);
      end else begin
        run_random(190, 1'b0);
      end
    end

    settle_bus(1'b1);
    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("one_wire_bus_master_core regression: pass");
    end else begin
      $display("one_wire_bus_master_core regression: fail");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin : watchdog
    #20_000_000;
    $display("one_wire_bus_master_core regression: fail");
    $finish;
  end

endmodule
